FILE: rtl/rrt_pkg.sv
// ============================================================================
// rrt_pkg - shared types and constants for the range reservation table
// Table geometry, field widths, result status codes and sequencer states.
// ============================================================================
package rrt_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES   = 4096;
    localparam int MAX_RANGE_BYTES = 512;

    // Field widths fixed by the request and result formats
    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 10;
    localparam int STATUS_W = 3;

    // Derived widths: entry index, fill count, stored entry {end, start}
    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int END_W   = ADDR_W + 1;
    localparam int ENTRY_W = END_W + ADDR_W;

    // Length clamp; a limit above the field range never bites
    localparam int SAT_LEN_INT = (MAX_RANGE_BYTES > (2**LEN_W - 1)) ?
                                 (2**LEN_W - 1) : MAX_RANGE_BYTES;
    localparam logic [LEN_W-1:0] SAT_LEN = LEN_W'(SAT_LEN_INT);

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_ADDR = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_LEN  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CONFLICT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_RESP = 3'b100
    } state_t;

endpackage

FILE: rtl/rrt_req_if.sv
// ============================================================================
// rrt_req_if - request channel of the range reservation table
// Valid/ready handshake carrying one start address and byte length per beat.
// ============================================================================
interface rrt_req_if;
    import rrt_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] start_address;
    logic [LEN_W-1:0]  byte_length;

    modport source (output valid, output start_address, output byte_length, input ready);
    modport sink   (input valid, input start_address, input byte_length, output ready);

endinterface

FILE: rtl/rrt_rsp_if.sv
// ============================================================================
// rrt_rsp_if - result channel of the range reservation table
// Valid/ready handshake carrying one status and conflict start per beat.
// ============================================================================
interface rrt_rsp_if;
    import rrt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   conflict_start;

    modport source (output valid, output status, output conflict_start, input ready);
    modport sink   (input valid, input status, input conflict_start, output ready);

endinterface

FILE: rtl/rrt_ram.sv
// ============================================================================
// rrt_ram - generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ============================================================================
module rrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Storage and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/range_reservation_table_core.sv
// ============================================================================
// range_reservation_table_core - overlap-checked address range table
// Appends non-overlapping [start, start+length) ranges; rejects the rest.
// ============================================================================
// One request at a time. A request with a zero address or zero length is
// answered without a scan (accept, then result). Otherwise the stored entries
// are scanned in fill order through the table RAM's single read port, one
// entry per cycle, up to and including the first overlapping one, or all of
// them when nothing overlaps. The result is held until taken; the block is
// ready again the cycle after.
// Lengths above 512 bytes are clamped to 512. The table starts empty after
// reset; entries are never removed.
module range_reservation_table_core (
    input  logic      clk,
    input  logic      rst_n,
    rrt_req_if.sink   req,
    rrt_rsp_if.source rsp
);
    import rrt_pkg::*;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                pend_reg, pend_next;
    logic [ADDR_W-1:0]   start_reg, start_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [END_W-1:0]    last_reg, last_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ADDR_W-1:0]   conf_reg, conf_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic [LEN_W-1:0]    req_len_sat;
    logic [ADDR_W-1:0]   rd_start;
    logic [END_W-1:0]    rd_end;
    logic                hit;
    logic                scan_done;

    // Table storage: each entry is {exclusive end, start}
    rrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Compare unit on the entry read last cycle
    assign rd_start  = ram_rdata[ADDR_W-1:0];
    assign rd_end    = ram_rdata[ENTRY_W-1:ADDR_W];
    assign hit       = pend_reg && ({1'b0, start_reg} < rd_end) &&
                       (last_reg >= {1'b0, rd_start});
    // all reads issued; the last one, if any, is compared this cycle
    assign scan_done = (idx_reg >= count_reg);

    // Length clamp at the request port
    assign req_len_sat = (req.byte_length > SAT_LEN) ? SAT_LEN : req.byte_length;

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        pend_next   = pend_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        last_next   = last_reg;
        status_next = status_reg;
        conf_next   = conf_reg;
        ram_we      = 1'b0;
        ram_waddr   = count_reg[IDX_W-1:0];
        ram_wdata   = {({1'b0, start_reg} + {{(END_W-LEN_W){1'b0}}, len_reg}), start_reg};
        ram_raddr   = idx_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    start_next  = req.start_address;
                    len_next    = req_len_sat;
                    last_next   = {1'b0, req.start_address}
                                + {{(END_W-LEN_W){1'b0}}, req_len_sat}
                                - END_W'(1);
                    idx_next    = '0;
                    pend_next   = 1'b0;
                    conf_next   = '0;
                    status_next = ST_OK;
                    if (req.start_address == '0)
                    begin
                        status_next = ST_ZERO_ADDR;
                        state_next  = S_RESP;
                    end
                    else if (req.byte_length == '0)
                    begin
                        status_next = ST_ZERO_LEN;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    status_next = ST_CONFLICT;
                    conf_next   = rd_start;
                    pend_next   = 1'b0;
                    state_next  = S_RESP;
                end
                else if (scan_done)
                begin
                    if (count_reg >= CNT_W'(TABLE_ENTRIES))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        status_next = ST_OK;
                        ram_we      = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                    end
                    pend_next  = 1'b0;
                    state_next = S_RESP;
                end
                else
                begin
                    // issue the next read; its data is compared next cycle
                    idx_next  = idx_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
            end

            S_RESP:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        start_reg  <= start_next;
        len_reg    <= len_next;
        last_reg   <= last_next;
        status_reg <= status_next;
        conf_reg   <= conf_next;
    end

    // Channel outputs
    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = (state_reg == S_RESP);
    assign rsp.status         = status_reg;
    assign rsp.conflict_start = conf_reg;

`ifndef ASSERT_OFF
    // Fill count never passes the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    // An append bumps the fill count by exactly one
    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("append without fill count step");

    // Conflict start is zero unless an overlap was reported
    a_conf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != ST_CONFLICT)) |-> (rsp.conflict_start == '0))
        else $error("conflict start set without conflict");

    // A pending compare always refers to a filled entry
    a_pend_filled: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> ((idx_reg != '0) && (idx_reg <= count_reg)))
        else $error("compare on an unfilled entry");
`endif

endmodule

FILE: sim/tb_range_reservation_table_core.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_range_reservation_table_core - self-checking bench for the range table
// Directed requests, then random traffic under several idle/stall mixes,
// then a few closing probes on the stored ranges. Each result beat is checked
// against an in-bench booking model, or against the fixed reply of a fixed row.
// ============================================================================
module tb_range_reservation_table_core;
    import rrt_pkg::*;

    localparam int          SHOW_LIMIT  = 100;
    localparam int          HOLD_CYCLES = 400;
    localparam int          RAND_PHASES = 4;
    localparam int          PHASE_ITEMS = 29;
    // Probe region is kept clear of all random traffic
    localparam logic [31:0] FILL_BASE   = 32'h6000_0000;
    localparam logic [31:0] WIN_BASE    = 32'h0001_0000;
    localparam logic [31:0] TOP_BASE    = 32'hFFFF_F000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   conflict_start;
    } reply_t;

    typedef struct packed {
        logic   fixed;
        reply_t reply;
    } note_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start_address;
        logic [LEN_W-1:0]  byte_length;
        logic              fixed;
        reply_t            reply;
    } row_t;

    logic clk;
    logic rst_n;

    rrt_req_if req_ch ();
    rrt_rsp_if rsp_ch ();

    range_reservation_table_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Booking model of the table
    logic [ADDR_W-1:0] booked_start [TABLE_ENTRIES];
    logic [END_W-1:0]  booked_end   [TABLE_ENTRIES];
    int                booked_count;

    reply_t pending_replies [$];
    note_t  fixed_notes     [$];
    row_t   directed_rows   [$];

    int errors;
    int shown;
    int items_sent;
    int directed_sent;
    int replies_checked;
    int status_seen [0:4];
    int sender_idle_pct;
    int receiver_stall_pct;
    bit hold_request;

    // Clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Outcome of one request; books the range when it is granted
    function automatic reply_t reserve_range(input logic [ADDR_W-1:0] start_address,
                                             input logic [LEN_W-1:0]  byte_length);
        reply_t             r;
        logic [LEN_W-1:0]   len;
        logic [END_W-1:0]   first_byte;
        logic [END_W-1:0]   last_byte;
        r.status         = ST_OK;
        r.conflict_start = '0;
        if (start_address == '0)
        begin
            r.status = ST_ZERO_ADDR;
            return r;
        end
        if (byte_length == '0)
        begin
            r.status = ST_ZERO_LEN;
            return r;
        end
        len        = (byte_length > MAX_RANGE_BYTES) ? LEN_W'(MAX_RANGE_BYTES) : byte_length;
        first_byte = {1'b0, start_address};
        last_byte  = first_byte + END_W'(len) - 1'b1;
        // first overlapping range in fill order wins
        for (int i = 0; i < booked_count; i++)
        begin
            if (first_byte < booked_end[i] && last_byte >= {1'b0, booked_start[i]})
            begin
                r.status         = ST_CONFLICT;
                r.conflict_start = booked_start[i];
                return r;
            end
        end
        if (booked_count >= TABLE_ENTRIES)
        begin
            r.status = ST_FULL;
            return r;
        end
        booked_start[booked_count] = start_address;
        booked_end[booked_count]   = first_byte + END_W'(len);
        booked_count++;
        return r;
    endfunction

    function automatic void add_row(input logic [ADDR_W-1:0]   start_address,
                                    input logic [LEN_W-1:0]    byte_length,
                                    input logic                fixed,
                                    input logic [STATUS_W-1:0] status,
                                    input logic [ADDR_W-1:0]   conflict_start);
        row_t r;
        r.start_address        = start_address;
        r.byte_length          = byte_length;
        r.fixed                = fixed;
        r.reply.status         = status;
        r.reply.conflict_start = conflict_start;
        directed_rows.push_back(r);
    endfunction

    // Offer one request beat; returns at the edge that accepts it
    task automatic send_request(input row_t r);
        note_t n;
        n.fixed = r.fixed;
        n.reply = r.reply;
        fixed_notes.push_back(n);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.start_address <= r.start_address;
        req_ch.byte_length   <= r.byte_length;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Mostly well-formed requests around stored ranges, plus noise
    task automatic random_request();
        row_t r;
        int   pick;
        int   k;
        pick    = $urandom_range(99);
        r.fixed = 1'b0;
        r.reply = '0;
        r.byte_length = ($urandom_range(3) == 0) ? LEN_W'($urandom_range(1, 1023))
                                                 : LEN_W'($urandom_range(1, 64));
        if (pick < 55)
            r.start_address = WIN_BASE + $urandom_range(0, 32'h8000);
        else if (pick < 70 && booked_count > 0)
        begin
            // land right against a stored range, above or below
            k = $urandom_range(0, booked_count - 1);
            r.byte_length = LEN_W'($urandom_range(1, 64));
            if ($urandom_range(1))
                r.start_address = booked_end[k][ADDR_W-1:0];
            else
                r.start_address = booked_start[k] - ADDR_W'(r.byte_length);
        end
        else if (pick < 80)
            r.start_address = TOP_BASE + $urandom_range(0, 32'hFFF);
        else if (pick < 87)
        begin
            r.start_address = '0;
            r.byte_length   = LEN_W'($urandom);
        end
        else if (pick < 93)
        begin
            r.start_address = $urandom | 32'h1;
            r.byte_length   = '0;
        end
        else
        begin
            r.start_address = $urandom;
            r.byte_length   = LEN_W'($urandom);
        end
        // keep the probe region untouched
        if (r.start_address[31:29] == 3'b011)
            r.start_address[31] = 1'b1;
        send_request(r);
    endtask

    task automatic wait_drained();
        while (pending_replies.size() != 0 || fixed_notes.size() != 0)
            @(posedge clk);
    endtask

    // Response ready, with random stalls and a long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Watch both channels: book accepted requests, check result beats
    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        reply_t booked;
        note_t  n;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.status         = rsp_ch.status;
                got.conflict_start = rsp_ch.conflict_start;
                replies_checked++;
                if (got.status <= ST_FULL)
                    status_seen[got.status]++;
                if (pending_replies.size() == 0)
                begin
                    errors++;
                    if (shown < SHOW_LIMIT)
                        $display("%0t: unexpected result beat, status %0d conflict_start %h",
                                 $time, got.status, got.conflict_start);
                    shown++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (got.status !== want.status)
                    begin
                        errors++;
                        if (shown < SHOW_LIMIT)
                            $display("%0t: status mismatch, expected %0d actual %0d",
                                     $time, want.status, got.status);
                        shown++;
                    end
                    if (got.conflict_start !== want.conflict_start)
                    begin
                        errors++;
                        if (shown < SHOW_LIMIT)
                            $display("%0t: conflict_start mismatch, expected %h actual %h",
                                     $time, want.conflict_start, got.conflict_start);
                        shown++;
                    end
                end
                if (shown == SHOW_LIMIT)
                begin
                    $display("%0t: further mismatches are counted but not shown", $time);
                    shown++;
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                booked = reserve_range(req_ch.start_address, req_ch.byte_length);
                n = (fixed_notes.size() != 0) ? fixed_notes.pop_front() : '0;
                pending_replies.push_back(n.fixed ? n.reply : booked);
            end
        end
    end

    // Stimulus
    initial
    begin
        errors             = 0;
        shown              = 0;
        items_sent         = 0;
        directed_sent      = 0;
        replies_checked    = 0;
        booked_count       = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_request       = 1'b0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.start_address <= '0;
        req_ch.byte_length   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows on an empty table: check order, edges, clamp, top end
        add_row(32'h0000_0000, 10'd0,    1'b1, ST_ZERO_ADDR, 32'h0);
        add_row(32'h0000_0000, 10'd5,    1'b1, ST_ZERO_ADDR, 32'h0);
        add_row(32'h0000_0100, 10'd0,    1'b1, ST_ZERO_LEN,  32'h0);
        add_row(32'h0000_1000, 10'd16,   1'b1, ST_OK,        32'h0);
        add_row(32'h0000_1000, 10'd1,    1'b1, ST_CONFLICT,  32'h0000_1000);
        add_row(32'h0000_0FFF, 10'd1,    1'b0, ST_OK,        32'h0);
        add_row(32'h0000_1010, 10'd1,    1'b0, ST_OK,        32'h0);
        add_row(32'h0000_0FF0, 10'd32,   1'b0, ST_OK,        32'h0);
        add_row(32'hFFFF_FFFF, 10'd1,    1'b0, ST_OK,        32'h0);
        add_row(32'hFFFF_FF00, 10'd1023, 1'b0, ST_OK,        32'h0);
        add_row(32'hFFFF_FE00, 10'd512,  1'b0, ST_OK,        32'h0);
        add_row(32'hFFFF_FE00, 10'd511,  1'b0, ST_OK,        32'h0);
        add_row(32'h0000_0001, 10'd1,    1'b0, ST_OK,        32'h0);
        add_row(32'h0000_2000, 10'd513,  1'b0, ST_OK,        32'h0);
        add_row(32'h0000_21FF, 10'd1,    1'b0, ST_OK,        32'h0);
        add_row(32'h0000_2200, 10'd1023, 1'b0, ST_OK,        32'h0);
        add_row(32'h0000_3000, 10'd512,  1'b0, ST_OK,        32'h0);
        add_row(32'h0000_33FF, 10'd2,    1'b0, ST_OK,        32'h0);
        add_row(32'hFFFF_FFFF, 10'd0,    1'b1, ST_ZERO_LEN,  32'h0);
        add_row(32'h8000_0000, 10'd1023, 1'b0, ST_OK,        32'h0);
        foreach (directed_rows[i])
            send_request(directed_rows[i]);
        directed_sent = items_sent;

        // Random traffic: no idling, sender idle, receiver stall, both light
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            sender_idle_pct    = (p == 1) ? 69 : (p == 3) ? 8 : 0;
            receiver_stall_pct = (p == 2) ? 69 : (p == 3) ? 8 : 0;
            // long receiver hold-off while requests keep coming
            if (p == 0)
                hold_request = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
                random_request();
        end

        // Closing probes: early conflict still reported, check order again
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        directed_rows.delete();
        add_row(32'h0000_1000, 10'd1,    1'b1, ST_CONFLICT,  32'h0000_1000);
        add_row(32'h0000_0000, 10'd1,    1'b1, ST_ZERO_ADDR, 32'h0);
        add_row(32'h0000_0005, 10'd0,    1'b1, ST_ZERO_LEN,  32'h0);
        add_row(32'hFFFF_FFFF, 10'd1023, 1'b0, ST_OK,        32'h0);
        add_row(FILL_BASE + 32'd1600, 10'd512, 1'b0, ST_OK,  32'h0);
        foreach (directed_rows[i])
            send_request(directed_rows[i]);
        directed_sent += directed_rows.size();

        req_ch.valid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);

        $display("Ran %0d requests (%0d directed), %0d results checked, table at %0d of %0d.",
                 items_sent, directed_sent, replies_checked, booked_count, TABLE_ENTRIES);
        $display("Results: %0d granted, %0d zero address, %0d zero length, %0d overlap, %0d full.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: reports TB_ERROR and stops a run that hangs
    initial
    begin
        #(64'd20_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule
